// ===== design/fsng_pkg.sv =====
// Shared types and constants for the FAT short-name generator.
// Used by the front end, the job queue and the back end. No dependencies.
`default_nettype none

package fsng_pkg;

	localparam int BASE_SLOTS = 8;
	localparam int EXT_LEN    = 3;
	localparam int SHORT_LEN  = 11;

	typedef logic [7:0] byte_t;

	localparam byte_t CH_DOT     = 8'h2E;
	localparam byte_t CH_SPACE   = 8'h20;
	localparam byte_t CH_TILDE   = 8'h7E;
	localparam byte_t CH_ZERO    = 8'h30;
	localparam byte_t CH_LOWER_A = 8'h61;
	localparam byte_t CH_LOWER_Z = 8'h7A;
	localparam byte_t CASE_DIFF  = 8'd32;
	localparam byte_t CK_MSB     = 8'h80;

	localparam logic [3:0] BASE_MAX = 4'd8;
	localparam logic [1:0] EXT_MAX  = 2'd3;
	localparam logic [9:0] ATT_MAX  = 10'd999;

	// one finished name as handed from the front end to the back end
	typedef struct packed {
		byte_t [BASE_SLOTS-1:0] base;
		logic  [3:0]            bcnt;
		byte_t [EXT_LEN-1:0]    ext;
		logic  [1:0]            ecnt;
		logic  [9:0]            att;
	} job_t;

endpackage

`default_nettype wire

// ===== design/fsng_front.sv =====
// Front end: takes name bytes, splits them into base and extension characters.
// Pushes a finished name into the job queue on the final byte. Uses fsng_pkg.
`default_nettype none

module fsng_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [7:0]     name_char,
	input  wire logic           is_final,
	input  wire logic [9:0]     attempt,
	input  wire logic           q_full,
	output logic                q_push,
	output fsng_pkg::job_t      q_data
);

	fsng_pkg::byte_t [fsng_pkg::BASE_SLOTS-1:0] base_q, base_nx;
	fsng_pkg::byte_t [fsng_pkg::EXT_LEN-1:0]    ext_q, ext_nx;
	logic [3:0] bcnt_q, bcnt_nx;
	logic [1:0] ecnt_q, ecnt_nx;
	logic       bclosed_q, bclosed_nx;
	logic       dot_q, dot_nx;
	fsng_pkg::byte_t up;
	logic       take;
	logic [9:0] att_sat;

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;
	assign q_push   = take && is_final;

	always_comb begin
		base_nx    = base_q;
		ext_nx     = ext_q;
		bcnt_nx    = bcnt_q;
		ecnt_nx    = ecnt_q;
		bclosed_nx = bclosed_q;
		dot_nx     = dot_q;
		up = (name_char inside {[fsng_pkg::CH_LOWER_A:fsng_pkg::CH_LOWER_Z]}) ?
			name_char - fsng_pkg::CASE_DIFF : name_char;
		if (name_char == fsng_pkg::CH_DOT) begin
			// every dot restarts the extension, the first one closes the base
			bclosed_nx = 1'b1;
			dot_nx     = 1'b1;
			ecnt_nx    = '0;
		end else begin
			if (!bclosed_q) begin
				if (name_char != fsng_pkg::CH_SPACE && bcnt_q < fsng_pkg::BASE_MAX) begin
					base_nx[bcnt_q[2:0]] = up;
					bcnt_nx = bcnt_q + 4'd1;
				end
				if (bcnt_nx >= fsng_pkg::BASE_MAX)
					bclosed_nx = 1'b1;
			end
			if (dot_q && ecnt_q < fsng_pkg::EXT_MAX) begin
				ext_nx[ecnt_q] = up;
				ecnt_nx = ecnt_q + 2'd1;
			end
		end
	end

	assign att_sat = (attempt > fsng_pkg::ATT_MAX) ? fsng_pkg::ATT_MAX : attempt;

	assign q_data = '{base: base_nx, bcnt: bcnt_nx, ext: ext_nx, ecnt: ecnt_nx,
		att: att_sat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q    <= '0;
			ecnt_q    <= '0;
			bclosed_q <= 1'b0;
			dot_q     <= 1'b0;
		end else if (take) begin
			if (is_final) begin
				bcnt_q    <= '0;
				ecnt_q    <= '0;
				bclosed_q <= 1'b0;
				dot_q     <= 1'b0;
			end else begin
				bcnt_q    <= bcnt_nx;
				ecnt_q    <= ecnt_nx;
				bclosed_q <= bclosed_nx;
				dot_q     <= dot_nx;
			end
		end
	end

	// character stores: only read below their counts
	always_ff @(posedge clk) begin
		if (take) begin
			base_q <= base_nx;
			ext_q  <= ext_nx;
		end
	end

endmodule

`default_nettype wire

// ===== design/fsng_queue.sv =====
// Short job queue between the front end and the back end.
// Holds fsng_pkg::job_t words; depth set by the DEPTH parameter (2 or more).
`default_nettype none

module fsng_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fsng_pkg::job_t push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output fsng_pkg::job_t      head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fsng_pkg::job_t slot_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push_ok, pop_ok;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign push_ok   = push && !full;
	assign pop_ok    = pop && not_empty;
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok)
			slot_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop_ok)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (push_ok && !pop_ok)
				cnt_q <= cnt_q + CW'(1);
			else if (pop_ok && !push_ok)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== design/fsng_back.sv =====
// Back end: turns one queued name into the 11 bytes of the 8.3 short name.
// Decimal digits by constant reciprocals, then a serial byte run with checksum. Uses fsng_pkg.
`default_nettype none

module fsng_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire fsng_pkg::job_t head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          short_byte,
	output logic [3:0]          byte_pos,
	output logic                run_end,
	output logic [7:0]          name_checksum
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_HUND  = 7'b0000010,
		ST_REM   = 7'b0000100,
		ST_TENS  = 7'b0001000,
		ST_ONES  = 7'b0010000,
		ST_BUILD = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t          state_q;
	fsng_pkg::job_t  job_q;
	logic [3:0]      hund_q, tens_q, ones_q;
	logic [6:0]      rem_q;
	fsng_pkg::byte_t [fsng_pkg::SHORT_LEN-1:0] nm_q, nm;
	fsng_pkg::byte_t sum_q, sum_nx;
	logic [3:0]      pos_q;
	logic [15:0]     hund_prod;
	logic [9:0]      rem_full;
	logic [14:0]     tens_prod;
	logic [6:0]      ones_full;
	logic [1:0]      digits;
	logic [3:0]      keep, off;
	fsng_pkg::byte_t [2:0] dig;
	logic            out_take;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = state_q == ST_EMIT;
	assign out_take  = out_valid && !out_stall;

	// x/100 = (x*41)>>12 for x < 1000; r/10 = (r*205)>>11 for r < 100
	assign hund_prod = 16'(job_q.att) * 16'd41;
	assign rem_full  = job_q.att - 10'({6'd0, hund_q} * 10'd100);
	assign tens_prod = 15'(rem_q) * 15'd205;
	assign ones_full = rem_q - 7'({3'd0, tens_q} * 7'd10);

	always_comb begin
		digits = (job_q.att < 10'd10) ? 2'd1 : (job_q.att < 10'd100) ? 2'd2 : 2'd3;
		keep = job_q.bcnt;
		if (keep + 4'd1 + {2'd0, digits} > fsng_pkg::BASE_MAX)
			keep = 4'd7 - {2'd0, digits};
		case (digits)
			2'd3: dig = {fsng_pkg::CH_ZERO + {4'd0, ones_q},
				fsng_pkg::CH_ZERO + {4'd0, tens_q}, fsng_pkg::CH_ZERO + {4'd0, hund_q}};
			2'd2: dig = {fsng_pkg::CH_SPACE, fsng_pkg::CH_ZERO + {4'd0, ones_q},
				fsng_pkg::CH_ZERO + {4'd0, tens_q}};
			default: dig = {fsng_pkg::CH_SPACE, fsng_pkg::CH_SPACE,
				fsng_pkg::CH_ZERO + {4'd0, ones_q}};
		endcase
		nm  = {fsng_pkg::SHORT_LEN{fsng_pkg::CH_SPACE}};
		off = '0;
		for (int i = 0; i < fsng_pkg::BASE_SLOTS; i++) begin
			off = 4'(i) - keep - 4'd1;
			if (4'(i) < keep)
				nm[i] = job_q.base[i];
			else if (4'(i) == keep)
				nm[i] = fsng_pkg::CH_TILDE;
			else if (off < {2'd0, digits})
				nm[i] = dig[off[1:0]];
		end
		for (int j = 0; j < fsng_pkg::EXT_LEN; j++) begin
			if (2'(j) < job_q.ecnt)
				nm[fsng_pkg::BASE_SLOTS + j] = job_q.ext[j];
		end
	end

	assign sum_nx = (sum_q[0] ? fsng_pkg::CK_MSB : 8'd0) + (sum_q >> 1) + nm_q[0];

	assign short_byte    = nm_q[0];
	assign byte_pos      = pos_q;
	assign run_end       = pos_q == 4'(fsng_pkg::SHORT_LEN - 1);
	assign name_checksum = run_end ? sum_nx : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE:  if (q_valid) state_q <= ST_HUND;
				ST_HUND:  state_q <= ST_REM;
				ST_REM:   state_q <= ST_TENS;
				ST_TENS:  state_q <= ST_ONES;
				ST_ONES:  state_q <= ST_BUILD;
				ST_BUILD: begin
					state_q <= ST_EMIT;
					pos_q   <= '0;
				end
				ST_EMIT: begin
					if (out_take) begin
						pos_q <= pos_q + 4'd1;
						if (run_end)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= head;
		if (state_q == ST_HUND)
			hund_q <= hund_prod[15:12];
		if (state_q == ST_REM)
			rem_q <= rem_full[6:0];
		if (state_q == ST_TENS)
			tens_q <= tens_prod[14:11];
		if (state_q == ST_ONES)
			ones_q <= ones_full[3:0];
		if (state_q == ST_BUILD) begin
			nm_q  <= nm;
			sum_q <= '0;
		end else if (out_take) begin
			nm_q  <= {fsng_pkg::CH_SPACE, nm_q[fsng_pkg::SHORT_LEN-1:1]};
			sum_q <= sum_nx;
		end
	end

endmodule

`default_nettype wire

// ===== design/fat_short_name_generator.sv =====
// The first short-name word can be taken once the final name byte is accepted and the
// queue pop, 4 digit steps and build are done; the 11 words then follow one a cycle
// when out_stall stays low. Throughput: one name byte per cycle into the front end while
// in_stall is low; the back end pops a name only when idle, and the queue absorbs bursts.
// Reset (arst_n low, asynchronous): all counters, queue pointers and the back-end FSM clear.
`default_nettype none

module fat_short_name_generator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] name_char,
	input  wire logic       is_final,
	input  wire logic [9:0] attempt,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      short_byte,
	output logic [3:0]      byte_pos,
	output logic            run_end,
	output logic [7:0]      name_checksum
);

	fsng_pkg::job_t push_data, head;
	logic q_push, q_full, q_pop, q_valid;

	fsng_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.name_char (name_char),
		.is_final  (is_final),
		.attempt   (attempt),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	fsng_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head)
	);

	fsng_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.short_byte    (short_byte),
		.byte_pos      (byte_pos),
		.run_end       (run_end),
		.name_checksum (name_checksum)
	);

endmodule

`default_nettype wire

// ===== design/fsng_checker.sv =====
// Port-level checks for fat_short_name_generator, attached by bind.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module fsng_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] name_char,
	input wire logic       is_final,
	input wire logic [9:0] attempt,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] short_byte,
	input wire logic [3:0] byte_pos,
	input wire logic       run_end,
	input wire logic [7:0] name_checksum
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=>
		(in_valid && $stable(name_char) && $stable(is_final) && $stable(attempt)))
		else $error("stalled input word changed");

	a_run_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_end == (byte_pos == 4'd10)))
		else $error("run_end does not match the last position");

	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_end) |-> (name_checksum == 8'd0))
		else $error("checksum nonzero before end of run");

	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !run_end) |=>
		(out_valid && byte_pos == $past(byte_pos) + 4'd1))
		else $error("short-name run broken or out of order");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(short_byte) && $stable(byte_pos)))
		else $error("stalled output word changed");

endmodule

bind fat_short_name_generator fsng_checker u_fsng_checker (.*);

`default_nettype wire

// ===== dv/short_name_checker.sv =====
`timescale 1ns / 100ps
// Checker for fat_short_name_generator: watches the name-byte and short-name channels,
// predicts the 11 words of each 8.3 name with its checksum, and compares in order.
// Depends on fsng_pkg for character constants and length limits.

module short_name_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] name_char,
	input  wire logic       is_final,
	input  wire logic [9:0] attempt,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] short_byte,
	input  wire logic [3:0] byte_pos,
	input  wire logic       run_end,
	input  wire logic [7:0] name_checksum,
	output int              errors,
	output int              pending
);

	typedef struct {
		fsng_pkg::byte_t ch;
		logic [3:0]      pos;
		logic            last;
		fsng_pkg::byte_t sum;
	} name_word_t;

	name_word_t expected_words[$];

	// gathered state of the name in progress
	fsng_pkg::byte_t base_chars [fsng_pkg::BASE_SLOTS];
	logic [3:0]      base_cnt;
	bit              base_done;
	fsng_pkg::byte_t ext_chars [fsng_pkg::EXT_LEN];
	logic [1:0]      ext_cnt;
	bit              dot_hit;

	function automatic fsng_pkg::byte_t upcase(input fsng_pkg::byte_t c);
		return (c >= fsng_pkg::CH_LOWER_A && c <= fsng_pkg::CH_LOWER_Z) ?
			c - fsng_pkg::CASE_DIFF : c;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		fsng_pkg::byte_t c;
		fsng_pkg::byte_t sn_bytes [fsng_pkg::SHORT_LEN];
		fsng_pkg::byte_t sum;
		int              att_v, digits, keep, p;
		name_word_t      want;
		if (!arst_n) begin
			expected_words.delete();
			errors    = 0;
			base_cnt  = '0;
			base_done = 0;
			ext_cnt   = '0;
			dot_hit   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: word with nothing expected: pos %0d byte %h",
						$time, byte_pos, short_byte);
					errors++;
				end else begin
					want = expected_words.pop_front();
					check_field("short_byte", want.ch, short_byte);
					check_field("byte_pos", want.pos, byte_pos);
					check_field("run_end", want.last, run_end);
					check_field("name_checksum", want.sum, name_checksum);
				end
			end
			if (in_valid && !in_stall) begin
				c = name_char;
				if (c == fsng_pkg::CH_DOT) begin
					// any dot closes the base and restarts the extension
					base_done = 1;
					dot_hit   = 1;
					ext_cnt   = '0;
				end else begin
					if (!base_done) begin
						if (c != fsng_pkg::CH_SPACE && base_cnt < fsng_pkg::BASE_MAX) begin
							base_chars[base_cnt[2:0]] = upcase(c);
							base_cnt++;
						end
						if (base_cnt >= fsng_pkg::BASE_MAX)
							base_done = 1;
					end
					if (dot_hit && ext_cnt < fsng_pkg::EXT_MAX) begin
						ext_chars[ext_cnt] = upcase(c);
						ext_cnt++;
					end
				end
				if (is_final) begin
					att_v  = (attempt > fsng_pkg::ATT_MAX) ? int'(fsng_pkg::ATT_MAX)
						: int'(attempt);
					digits = (att_v < 10) ? 1 : (att_v < 100) ? 2 : 3;
					for (int i = 0; i < fsng_pkg::SHORT_LEN; i++)
						sn_bytes[i] = fsng_pkg::CH_SPACE;
					keep = base_cnt;
					if (keep + 1 + digits > fsng_pkg::BASE_SLOTS)
						keep = fsng_pkg::BASE_SLOTS - 1 - digits;
					for (int i = 0; i < keep; i++)
						sn_bytes[i] = base_chars[i];
					p = keep;
					sn_bytes[p] = fsng_pkg::CH_TILDE;
					p++;
					if (digits == 3) begin
						sn_bytes[p] = fsng_pkg::CH_ZERO + fsng_pkg::byte_t'(att_v / 100);
						p++;
					end
					if (digits >= 2) begin
						sn_bytes[p] = fsng_pkg::CH_ZERO + fsng_pkg::byte_t'((att_v / 10) % 10);
						p++;
					end
					sn_bytes[p] = fsng_pkg::CH_ZERO + fsng_pkg::byte_t'(att_v % 10);
					for (int i = 0; i < ext_cnt; i++)
						sn_bytes[fsng_pkg::BASE_SLOTS + i] = ext_chars[i];
					sum = '0;
					for (int i = 0; i < fsng_pkg::SHORT_LEN; i++) begin
						sum = {sum[0], sum[7:1]} + sn_bytes[i];
						expected_words.push_back('{sn_bytes[i], 4'(i),
							i == fsng_pkg::SHORT_LEN - 1,
							(i == fsng_pkg::SHORT_LEN - 1) ? sum : 8'h00});
					end
					base_cnt  = '0;
					base_done = 0;
					ext_cnt   = '0;
					dot_hit   = 0;
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the fat_short_name_generator testbench: clock, reset, name-byte stimulus,
// receiver stalls and the verdict. Depends on fsng_pkg and short_name_checker.

module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 350;
	localparam int HOLD_CYCLES = 400;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] name_char;
	logic       is_final;
	logic [9:0] attempt;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] short_byte;
	logic [3:0] byte_pos;
	logic       run_end;
	logic [7:0] name_checksum;

	int    errors;
	int    pending;
	int    items_sent;
	int    cycles;
	bit    in_idle_en;
	bit    out_idle_en;
	bit    hold_req;
	fsng_pkg::byte_t name_bytes[$];

	fat_short_name_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.name_char     (name_char),
		.is_final      (is_final),
		.attempt       (attempt),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.short_byte    (short_byte),
		.byte_pos      (byte_pos),
		.run_end       (run_end),
		.name_checksum (name_checksum)
	);

	short_name_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.name_char     (name_char),
		.is_final      (is_final),
		.attempt       (attempt),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.short_byte    (short_byte),
		.byte_pos      (byte_pos),
		.run_end       (run_end),
		.name_checksum (name_checksum),
		.errors        (errors),
		.pending       (pending)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request so the queue fills
	initial begin : receiver
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_used) begin
				hold_used = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else
				out_stall <= out_idle_en && ($urandom_range(99) < 36);
		end
	end

	// entered and left just after a falling edge
	task automatic send_word(input fsng_pkg::byte_t c, input logic fin,
		input logic [9:0] att);
		while (in_idle_en && $urandom_range(99) < 36) begin
			in_valid  <= 0;
			name_char <= fsng_pkg::byte_t'($urandom_range(255));
			is_final  <= 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid  <= 1;
		name_char <= c;
		is_final  <= fin;
		attempt   <= att;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_name(input logic [9:0] att);
		int n;
		n = name_bytes.size();
		for (int i = 0; i < n; i++)
			send_word(name_bytes[i], i == n - 1,
				(i == n - 1) ? att : 10'($urandom_range(1023)));
	endtask

	task automatic load_text(input string s);
		name_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			name_bytes.push_back(fsng_pkg::byte_t'(s[i]));
	endtask

	function automatic fsng_pkg::byte_t pick_char();
		case ($urandom_range(9))
			0, 1, 2, 3: return fsng_pkg::CH_LOWER_A + fsng_pkg::byte_t'($urandom_range(25));
			4, 5:       return fsng_pkg::CH_LOWER_A - fsng_pkg::CASE_DIFF
				+ fsng_pkg::byte_t'($urandom_range(25));
			6:          return fsng_pkg::CH_ZERO + fsng_pkg::byte_t'($urandom_range(9));
			7:          return fsng_pkg::CH_SPACE;
			default:    return fsng_pkg::byte_t'($urandom_range(255));
		endcase
	endfunction

	initial begin : stimulus
		logic [9:0] att;
		arst_n      = 0;
		in_valid    = 0;
		name_char   = '0;
		is_final    = 0;
		attempt     = '0;
		in_idle_en  = 1;
		out_idle_en = 1;
		hold_req    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: one-byte name, attempt zero
		load_text("z");
		send_name(10'd0);
		// lone dot: empty base, attempt saturates
		load_text(".");
		send_name(10'd1023);
		// repeated dots restart the extension
		load_text("ab.c.de");
		send_name(10'd5);
		// zero byte, top byte, space, neighbors of the lower-case range
		name_bytes = '{8'h00, 8'hFF, fsng_pkg::CH_SPACE, 8'h60, 8'h7B};
		send_name(10'd42);
		// base fills at eight, ninth char dropped
		load_text("abcdefghI");
		send_name(10'd100);

		while (items_sent < ITEM_TARGET) begin
			if (!hold_req && items_sent > 120)
				hold_req = 1;
			in_idle_en  = !(items_sent > 200 && items_sent < 270);
			out_idle_en = in_idle_en;
			name_bytes.delete();
			if ($urandom_range(9) == 0) begin
				// noise: raw bytes with dots sprinkled in
				repeat ($urandom_range(1, 20))
					name_bytes.push_back(($urandom_range(3) == 0) ? fsng_pkg::CH_DOT
						: fsng_pkg::byte_t'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(0, 11))
					name_bytes.push_back(pick_char());
				if ($urandom_range(9) < 8) begin
					name_bytes.push_back(fsng_pkg::CH_DOT);
					repeat ($urandom_range(0, 5))
						name_bytes.push_back(pick_char());
					if ($urandom_range(9) < 2) begin
						name_bytes.push_back(fsng_pkg::CH_DOT);
						repeat ($urandom_range(0, 4))
							name_bytes.push_back(pick_char());
					end
				end
				if (name_bytes.size() == 0)
					name_bytes.push_back(pick_char());
			end
			case ($urandom_range(3))
				0:       att = 10'($urandom_range(1, 9));
				1:       att = 10'($urandom_range(10, 99));
				2:       att = 10'($urandom_range(100, 999));
				default: att = 10'($urandom_range(1023));
			endcase
			send_name(att);
		end
		in_valid <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/fsng_pkg.sv
design/fsng_front.sv
design/fsng_queue.sv
design/fsng_back.sv
design/fat_short_name_generator.sv
design/fsng_checker.sv
dv/short_name_checker.sv
dv/tb_top.sv
